>>> rtl/segx_pkg.sv
// Shared widths, payload structs and divider pipeline types for the segment intersection block.
`default_nettype none

package segx_pkg;

  localparam int COORD_WIDTH = 16;
  // Endpoint differences.
  localparam int DIFF_W = COORD_WIDTH + 1;
  // Products of two differences, and the cross products built from them.
  localparam int PROD_W = 2 * DIFF_W;
  localparam int D_W = PROD_W + 1;
  // Products of two coordinates, and the line constants built from them.
  localparam int CP_W = 2 * COORD_WIDTH;
  localparam int CA_W = CP_W + 1;
  // Numerator terms and numerators of the meeting point.
  localparam int NP_W = CA_W + DIFF_W;
  localparam int NUM_W = NP_W + 1;
  // Partial remainder in the divider chain.
  localparam int REM_W = NUM_W + 1;
  // Edges from the accepting edge to the edge that takes the result.
  localparam int LATENCY = COORD_WIDTH + 7;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_end_x;
    coord_t b_end_y;
  } operands_t;

  typedef struct packed {
    logic   hit;
    logic   parallel;
    coord_t meet_x;
    coord_t meet_y;
    logic   overflow;
  } result_t;

  typedef struct packed {
    logic [REM_W-1:0]       rem;
    logic [COORD_WIDTH-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic hit;
    logic parallel;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } div_flags_t;

  typedef struct packed {
    div_flags_t       flags;
    logic [REM_W-1:0] divisor;
    div_lane_t        lane_x;
    div_lane_t        lane_y;
  } div_stage_t;

endpackage

`default_nettype wire

>>> rtl/segx_front.sv
// Front pipeline: differences, cross products, hit test, numerators and divider setup.
`default_nettype none

module segx_front
  import segx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire operands_t  operands,
  output logic            out_valid,
  output div_stage_t      out_stage
);

  logic [5:0] valid_pipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else begin
      valid_pipe <= {valid_pipe[4:0], in_valid};
    end
  end

  assign out_valid = valid_pipe[5];

  // Stage A: direction vectors and coordinate products.
  logic signed [DIFF_W-1:0] rx, ry, sx, sy, wx, wy;
  logic signed [CP_W-1:0]   pa1, pa2, pb1, pb2;

  always_ff @(posedge clk) begin
    rx  <= DIFF_W'(operands.a_end_x) - DIFF_W'(operands.a_start_x);
    ry  <= DIFF_W'(operands.a_end_y) - DIFF_W'(operands.a_start_y);
    sx  <= DIFF_W'(operands.b_end_x) - DIFF_W'(operands.b_start_x);
    sy  <= DIFF_W'(operands.b_end_y) - DIFF_W'(operands.b_start_y);
    wx  <= DIFF_W'(operands.b_start_x) - DIFF_W'(operands.a_start_x);
    wy  <= DIFF_W'(operands.b_start_y) - DIFF_W'(operands.a_start_y);
    pa1 <= CP_W'(operands.a_start_x) * CP_W'(operands.a_end_y);
    pa2 <= CP_W'(operands.a_start_y) * CP_W'(operands.a_end_x);
    pb1 <= CP_W'(operands.b_start_x) * CP_W'(operands.b_end_y);
    pb2 <= CP_W'(operands.b_start_y) * CP_W'(operands.b_end_x);
  end

  // Stage B: difference products and line constants.
  logic signed [PROD_W-1:0] m_d1, m_d2, m_t1, m_t2, m_u1, m_u2;
  logic signed [CA_W-1:0]   ca, cb;
  logic signed [DIFF_W-1:0] b_rx, b_ry, b_sx, b_sy;

  always_ff @(posedge clk) begin
    m_d1 <= PROD_W'(rx) * PROD_W'(sy);
    m_d2 <= PROD_W'(ry) * PROD_W'(sx);
    m_t1 <= PROD_W'(wx) * PROD_W'(sy);
    m_t2 <= PROD_W'(wy) * PROD_W'(sx);
    m_u1 <= PROD_W'(wx) * PROD_W'(ry);
    m_u2 <= PROD_W'(wy) * PROD_W'(rx);
    ca   <= CA_W'(pa1) - CA_W'(pa2);
    cb   <= CA_W'(pb1) - CA_W'(pb2);
    b_rx <= rx;
    b_ry <= ry;
    b_sx <= sx;
    b_sy <= sy;
  end

  // Stage C: denominator, t and u numerators, meeting point numerator terms.
  logic signed [D_W-1:0]  den, tn, un;
  logic signed [NP_W-1:0] nx_p, nx_q, ny_p, ny_q;

  always_ff @(posedge clk) begin
    den  <= D_W'(m_d1) - D_W'(m_d2);
    tn   <= D_W'(m_t1) - D_W'(m_t2);
    un   <= D_W'(m_u1) - D_W'(m_u2);
    nx_p <= NP_W'(cb) * NP_W'(b_rx);
    nx_q <= NP_W'(ca) * NP_W'(b_sx);
    ny_p <= NP_W'(cb) * NP_W'(b_ry);
    ny_q <= NP_W'(ca) * NP_W'(b_sy);
  end

  // Stage D: numerators, range test on t and u, parallel detect.
  function automatic logic in_unit(logic signed [D_W-1:0] num, logic signed [D_W-1:0] d);
    logic res;
    if (d > 0) begin
      res = (num >= 0) && (num <= d);
    end else begin
      res = (num <= 0) && (num >= d);
    end
    return res;
  endfunction

  logic signed [NUM_W-1:0] nx, ny;
  logic signed [D_W-1:0]   d_den;
  logic                    d_hit, d_par;

  always_ff @(posedge clk) begin
    nx    <= NUM_W'(nx_p) - NUM_W'(nx_q);
    ny    <= NUM_W'(ny_p) - NUM_W'(ny_q);
    d_den <= den;
    d_hit <= in_unit(tn, den) && in_unit(un, den);
    d_par <= (den == '0);
  end

  // Stage E: magnitudes and quotient signs.
  logic [NUM_W-1:0] nx_mag, ny_mag;
  logic [D_W-1:0]   den_mag;
  logic             e_neg_x, e_neg_y, e_hit, e_par;

  always_ff @(posedge clk) begin
    nx_mag  <= nx[NUM_W-1] ? -nx : nx;
    ny_mag  <= ny[NUM_W-1] ? -ny : ny;
    den_mag <= d_den[D_W-1] ? -d_den : d_den;
    e_neg_x <= nx[NUM_W-1] ^ d_den[D_W-1];
    e_neg_y <= ny[NUM_W-1] ^ d_den[D_W-1];
    e_hit   <= d_hit;
    e_par   <= d_par;
  end

  // Stage F: flag quotients of 2^COORD_WIDTH or more, load the divider chain.
  logic [REM_W-1:0] den_top;

  assign den_top = REM_W'(den_mag) << COORD_WIDTH;

  always_ff @(posedge clk) begin
    out_stage.flags.hit      <= e_hit;
    out_stage.flags.parallel <= e_par;
    out_stage.flags.neg_x    <= e_neg_x;
    out_stage.flags.neg_y    <= e_neg_y;
    out_stage.flags.ovf_x    <= REM_W'(nx_mag) >= den_top;
    out_stage.flags.ovf_y    <= REM_W'(ny_mag) >= den_top;
    out_stage.divisor        <= REM_W'(den_mag) << (COORD_WIDTH - 1);
    out_stage.lane_x.rem     <= REM_W'(nx_mag);
    out_stage.lane_x.quo     <= '0;
    out_stage.lane_y.rem     <= REM_W'(ny_mag);
    out_stage.lane_y.quo     <= '0;
  end

endmodule

`default_nettype wire

>>> rtl/segx_div_cell.sv
// One restoring division step for both meeting point coordinates.
`default_nettype none

module segx_div_cell
  import segx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire div_stage_t  in_stage,
  output logic             out_valid,
  output div_stage_t       out_stage
);

  // Subtract the aligned divisor where it fits, then shift the remainder up.
  function automatic div_lane_t step(div_lane_t lane, logic [REM_W-1:0] divisor);
    div_lane_t res;
    logic      take;
    take     = lane.rem >= divisor;
    res.rem  = take ? ((lane.rem - divisor) << 1) : (lane.rem << 1);
    res.quo  = {lane.quo[COORD_WIDTH-2:0], take};
    return res;
  endfunction

  div_stage_t stage_next;

  always_comb begin
    stage_next        = in_stage;
    stage_next.lane_x = step(in_stage.lane_x, in_stage.divisor);
    stage_next.lane_y = step(in_stage.lane_y, in_stage.divisor);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_stage <= stage_next;
  end

endmodule

`default_nettype wire

>>> rtl/segment_intersection_2d.sv
// Top level: 2D segment intersection with hit test and saturated meeting point.
//
// Operands enter on start; the block never raises busy, so a new pair of
// segments is accepted at every rising edge with start high. Each pair gives
// exactly one result, shown on result for one cycle with done high, and taken
// at the edge that ends that cycle; the receiver cannot stall the block.
// Each result passes through six front stages for the cross products,
// numerators and magnitudes, one divider cell per quotient bit, and the
// output register. Throughput is one pair per cycle, set by the fully
// pipelined chain of division cells.
// hit reports that both segment parameters lie in the closed range [0,1].
// meet_x and meet_y are the meeting point of the infinite lines, truncated
// toward zero, saturated with overflow set when out of range. Parallel lines
// give parallel set and all other fields zero.
// Reset (rst, synchronous) drops every transaction in flight; no result is
// produced for them.
`default_nettype none

module segment_intersection_2d
  import segx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire operands_t  operands,
  output logic            done,
  output result_t         result
);

  typedef struct packed {
    coord_t value;
    logic   ovf;
  } sat_t;

  assign busy = 1'b0;

  logic       chain_valid [COORD_WIDTH+1];
  div_stage_t chain_stage [COORD_WIDTH+1];

  segx_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .operands  (operands),
    .out_valid (chain_valid[0]),
    .out_stage (chain_stage[0])
  );

  for (genvar i = 0; i < COORD_WIDTH; i++) begin : g_cell
    segx_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_stage  (chain_stage[i]),
      .out_valid (chain_valid[i+1]),
      .out_stage (chain_stage[i+1])
    );
  end

  // Clamp the unsigned quotient to the coordinate range and apply the sign.
  function automatic sat_t saturate(logic [COORD_WIDTH-1:0] quo, logic neg, logic big);
    sat_t                   res;
    logic [COORD_WIDTH-1:0] lim;
    logic [COORD_WIDTH-1:0] mag;
    lim = neg ? {1'b1, {(COORD_WIDTH-1){1'b0}}} : {1'b0, {(COORD_WIDTH-1){1'b1}}};
    if (big || (quo > lim)) begin
      res.ovf = 1'b1;
      mag     = lim;
    end else begin
      res.ovf = 1'b0;
      mag     = quo;
    end
    res.value = neg ? coord_t'(-mag) : coord_t'(mag);
    return res;
  endfunction

  div_stage_t last;
  sat_t       sat_x, sat_y;
  result_t    result_next;

  assign last  = chain_stage[COORD_WIDTH];
  assign sat_x = saturate(last.lane_x.quo, last.flags.neg_x, last.flags.ovf_x);
  assign sat_y = saturate(last.lane_y.quo, last.flags.neg_y, last.flags.ovf_y);

  always_comb begin
    if (last.flags.parallel) begin
      result_next          = '0;
      result_next.parallel = 1'b1;
    end else begin
      result_next.hit      = last.flags.hit;
      result_next.parallel = 1'b0;
      result_next.meet_x   = sat_x.value;
      result_next.meet_y   = sat_y.value;
      result_next.overflow = sat_x.ovf || sat_y.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain_valid[COORD_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("accepted transaction produced no result at the expected cycle");

  a_latency_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching accepted transaction");

  a_parallel_clear: assert property (@(posedge clk) disable iff (rst)
    done && result.parallel |->
      !result.hit && !result.overflow && result.meet_x == '0 && result.meet_y == '0)
    else $error("parallel result carries nonzero fields");

  a_ovf_saturated: assert property (@(posedge clk) disable iff (rst)
    done && result.overflow |->
      result.meet_x == COORD_MAX || result.meet_x == COORD_MIN ||
      result.meet_y == COORD_MAX || result.meet_y == COORD_MIN)
    else $error("overflow set without a saturated coordinate");

endmodule

`default_nettype wire
